[design/infix_add_sub_evaluator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the infix add/sub evaluator
// Shared property forms; clk and rst_n are taken from the using module.
// ----------------------------------------------------------------------------
`ifndef INFIX_ADD_SUB_EVALUATOR_CORE_ASSERT_SVH
`define INFIX_ADD_SUB_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define IAE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IAE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/iae_pkg.sv]
// ----------------------------------------------------------------------------
// iae_pkg
// Types and constants shared by the infix add/sub evaluator modules.
// ----------------------------------------------------------------------------
package iae_pkg;

    localparam int unsigned DATA_W         = 32;
    localparam int unsigned CMD_FIFO_DEPTH = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_ADD,
        CMD_SUB
    } cmd_kind_t;

    // Operator waiting at the current parenthesis level.
    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_ADD,
        PEND_SUB
    } pend_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic {
        BK_EXEC,
        BK_FINISH
    } back_state_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              has_num;
        logic              last;
        logic [DATA_W-1:0] num;
    } cmd_t;

endpackage

[design/iae_ram.sv]
// ----------------------------------------------------------------------------
// iae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iae_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/iae_front.sv]
// ----------------------------------------------------------------------------
// iae_front
// Takes characters, builds decimal numbers and issues stack commands.
// ----------------------------------------------------------------------------
module iae_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    char_code,
    input  logic          end_of_expression,
    output logic          cmd_wr,
    output iae_pkg::cmd_t cmd_data,
    input  logic          cmd_full
);
    import iae_pkg::*;

    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              pend_reg, pend_next;
    logic              accept;
    logic              is_digit;
    logic [DATA_W-1:0] acc_digit;
    cmd_kind_t         kind;

    assign full      = cmd_full;
    assign accept    = push && !cmd_full;
    assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    // acc * 10 + digit; low nibble of '0'..'9' is the digit
    assign acc_digit = (acc_reg << 3) + (acc_reg << 1)
                     + {{(DATA_W-4){1'b0}}, char_code[3:0]};

    always_comb
    begin
        case (char_code)
            CH_OPEN:  kind = CMD_OPEN;
            CH_CLOSE: kind = CMD_CLOSE;
            CH_PLUS:  kind = CMD_ADD;
            CH_MINUS: kind = CMD_SUB;
            default:  kind = CMD_NONE;
        endcase
    end

    always_comb
    begin
        cmd_data.kind    = is_digit ? CMD_NONE : kind;
        cmd_data.has_num = is_digit ? 1'b1 : pend_reg;
        cmd_data.last    = end_of_expression;
        cmd_data.num     = is_digit ? acc_digit : acc_reg;
        cmd_wr           = accept && (!is_digit || end_of_expression);

        acc_next  = acc_reg;
        pend_next = pend_reg;
        if (accept)
        begin
            if (is_digit && !end_of_expression)
            begin
                acc_next  = acc_digit;
                pend_next = 1'b1;
            end
            else
            begin
                acc_next  = '0;
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

endmodule

[design/iae_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// iae_cmd_fifo
// Short command queue between the character front end and the stack engine.
// ----------------------------------------------------------------------------
module iae_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  iae_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output iae_pkg::cmd_t rd_data,
    output logic          empty
);
    import iae_pkg::*;

    localparam int unsigned AW = $clog2(CMD_FIFO_DEPTH);

    cmd_t          mem_reg [CMD_FIFO_DEPTH];
    logic [AW:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW:0]   rd_ptr_reg, rd_ptr_next;

    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[AW] != rd_ptr_reg[AW])
                  && (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign rd_data = mem_reg[rd_ptr_reg[AW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en && !full)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en && !empty)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

[design/iae_back.sv]
// ----------------------------------------------------------------------------
// iae_back
// Stack engine: executes commands against the value and level stacks.
// ----------------------------------------------------------------------------
`include "infix_add_sub_evaluator_core_assert.svh"

module iae_back #(
    parameter int unsigned VALUE_DEPTH    = 32,
    parameter int unsigned OPERATOR_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_empty,
    output logic                              cmd_rd,
    input  iae_pkg::cmd_t                     cmd_data,
    input  logic                              out_pop,
    output logic                              out_empty,
    output logic signed [iae_pkg::DATA_W-1:0] value,
    output logic [1:0]                        status
);
    import iae_pkg::*;

    localparam int unsigned VCW = $clog2(VALUE_DEPTH + 1);
    localparam int unsigned VAW = $clog2(VALUE_DEPTH);
    localparam int unsigned OCW = $clog2(OPERATOR_DEPTH + 1);
    localparam int unsigned LAW = $clog2(OPERATOR_DEPTH);
    localparam logic [VCW-1:0] VFULL = VCW'(VALUE_DEPTH);
    localparam logic [OCW-1:0] OFULL = OCW'(OPERATOR_DEPTH);

    back_state_t       state_reg, state_next;
    logic [VCW-1:0]    vcount_reg, vcount_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] sec_reg, sec_next;
    logic [OCW-1:0]    opc_reg, opc_next;
    logic [OCW-1:0]    lvl_reg, lvl_next;
    pend_t             pend_reg, pend_next;
    status_t           err_reg, err_next;
    logic              lfwd_reg, lfwd_next;
    pend_t             lfwd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;

    logic              v_we;
    logic [VAW-1:0]    v_waddr, v_raddr;
    logic [DATA_W-1:0] v_wdata, v_rdata;
    logic              l_we;
    logic [LAW-1:0]    l_waddr, l_raddr;
    logic [1:0]        l_wdata, l_rdata;

    logic [VCW-1:0]    vc_m1, vc_m2, vnext_m3;
    logic [OCW-1:0]    lnext_m1;
    logic              do_reduce, vals_short, with_num, open_fire, fin_fire;
    logic [DATA_W-1:0] alu_a, alu_b, alu_res;
    pend_t             lvl_top;
    status_t           fault;
    status_t           fin_status;
    logic [DATA_W-1:0] fin_value;

    // ---- stacks: every value entry, saved operator per open level
    iae_ram #(.WIDTH(DATA_W), .DEPTH(VALUE_DEPTH)) u_vram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    iae_ram #(.WIDTH(2), .DEPTH(OPERATOR_DEPTH)) u_lram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    assign vc_m1    = vcount_reg - 1'b1;
    assign vc_m2    = vcount_reg - VCW'(2);
    // prefetch the entry two below the next top
    assign vnext_m3 = vcount_next - VCW'(3);
    assign v_raddr  = vnext_m3[VAW-1:0];
    assign lnext_m1 = lvl_next - 1'b1;
    assign l_raddr  = lnext_m1[LAW-1:0];
    assign l_waddr  = lvl_reg[LAW-1:0];
    assign l_wdata  = pend_reg;
    assign lvl_top  = lfwd_reg ? lfwd_data_reg : pend_t'(l_rdata);

    assign do_reduce  = (cmd_data.kind == CMD_CLOSE || cmd_data.kind == CMD_ADD
                         || cmd_data.kind == CMD_SUB) && (pend_reg != PEND_NONE);
    assign vals_short = cmd_data.has_num ? (vcount_reg == '0) : (vcount_reg < VCW'(2));

    // one shared adder
    assign with_num = (state_reg == BK_EXEC) && cmd_data.has_num;
    assign alu_a    = with_num ? top_reg : sec_reg;
    assign alu_b    = with_num ? cmd_data.num : top_reg;
    assign alu_res  = (pend_reg == PEND_SUB) ? (alu_a - alu_b) : (alu_a + alu_b);

    assign fin_fire = (state_reg == BK_FINISH) && (!out_valid_reg || out_pop);

    // first failing check of a command
    always_comb
    begin
        fault = ST_OK;
        if (cmd_data.has_num && vcount_reg == VFULL)
            fault = ST_OVERFLOW;
        else if (do_reduce && vals_short)
            fault = ST_MALFORMED;
        else
        begin
            case (cmd_data.kind)
                CMD_OPEN:
                    if (opc_reg == OFULL)
                        fault = ST_OVERFLOW;
                CMD_CLOSE:
                    if (lvl_reg == '0)
                        fault = ST_MALFORMED;
                CMD_ADD, CMD_SUB:
                    if (!do_reduce && opc_reg == OFULL)
                        fault = ST_OVERFLOW;
                default:
                    fault = ST_OK;
            endcase
        end
    end

    // final reduction and result
    always_comb
    begin
        fin_status = err_reg;
        fin_value  = '0;
        if (err_reg == ST_OK)
        begin
            if (pend_reg != PEND_NONE)
            begin
                if (vcount_reg < VCW'(2))
                    fin_status = ST_MALFORMED;
                else
                    fin_value = alu_res;
            end
            else if (vcount_reg == '0)
                fin_status = ST_MALFORMED;
            else
                fin_value = top_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        vcount_next     = vcount_reg;
        top_next        = top_reg;
        sec_next        = sec_reg;
        opc_next        = opc_reg;
        lvl_next        = lvl_reg;
        pend_next       = pend_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !out_pop;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        cmd_rd          = 1'b0;
        v_we            = 1'b0;
        v_waddr         = vcount_reg[VAW-1:0];
        v_wdata         = cmd_data.num;
        l_we            = 1'b0;
        open_fire       = 1'b0;

        case (state_reg)
            BK_EXEC:
            begin
                if (!cmd_empty)
                begin
                    cmd_rd = 1'b1;
                    if (cmd_data.last)
                        state_next = BK_FINISH;
                    if (err_reg == ST_OK && fault != ST_OK)
                        err_next = fault;
                    else if (err_reg == ST_OK)
                    begin
                        // value stack
                        if (do_reduce)
                        begin
                            top_next = alu_res;
                            v_we     = 1'b1;
                            v_wdata  = alu_res;
                            if (cmd_data.has_num)
                                v_waddr = vc_m1[VAW-1:0];
                            else
                            begin
                                v_waddr     = vc_m2[VAW-1:0];
                                sec_next    = v_rdata;
                                vcount_next = vc_m1;
                            end
                        end
                        else if (cmd_data.has_num)
                        begin
                            top_next    = cmd_data.num;
                            sec_next    = top_reg;
                            v_we        = 1'b1;
                            vcount_next = vcount_reg + 1'b1;
                        end
                        // operator / level stack
                        case (cmd_data.kind)
                            CMD_OPEN:
                            begin
                                l_we      = 1'b1;
                                open_fire = 1'b1;
                                lvl_next  = lvl_reg + 1'b1;
                                pend_next = PEND_NONE;
                                opc_next  = opc_reg + 1'b1;
                            end
                            CMD_CLOSE:
                            begin
                                lvl_next  = lvl_reg - 1'b1;
                                pend_next = lvl_top;
                                opc_next  = do_reduce ? opc_reg - OCW'(2) : opc_reg - 1'b1;
                            end
                            CMD_ADD, CMD_SUB:
                            begin
                                pend_next = (cmd_data.kind == CMD_ADD) ? PEND_ADD : PEND_SUB;
                                opc_next  = do_reduce ? opc_reg : opc_reg + 1'b1;
                            end
                            default:
                            begin
                                pend_next = pend_reg;
                            end
                        endcase
                    end
                end
            end
            BK_FINISH:
            begin
                if (fin_fire)
                begin
                    state_next      = BK_EXEC;
                    out_valid_next  = 1'b1;
                    out_value_next  = fin_value;
                    out_status_next = fin_status;
                    vcount_next     = '0;
                    opc_next        = '0;
                    lvl_next        = '0;
                    pend_next       = PEND_NONE;
                    err_next        = ST_OK;
                end
            end
            default:
            begin
                state_next = BK_EXEC;
            end
        endcase
    end

    assign lfwd_next = open_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_EXEC;
            vcount_reg    <= '0;
            opc_reg       <= '0;
            lvl_reg       <= '0;
            pend_reg      <= PEND_NONE;
            err_reg       <= ST_OK;
            lfwd_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            opc_reg       <= opc_next;
            lvl_reg       <= lvl_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            lfwd_reg      <= lfwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        sec_reg        <= sec_next;
        lfwd_data_reg  <= pend_reg;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign out_empty = !out_valid_reg;
    assign value     = $signed(out_value_reg);
    assign status    = out_status_reg;

    `IAE_ASSERT_IMP(a_vcount_bound, 1'b1, vcount_reg <= VFULL, "value count past depth")
    `IAE_ASSERT_IMP(a_lvl_within_opc, 1'b1, lvl_reg <= opc_reg, "open levels exceed operators")
    `IAE_ASSERT_NEXT(a_clear_after_result, fin_fire, (vcount_reg == '0) && (opc_reg == '0) && (err_reg == ST_OK) && (state_reg == BK_EXEC), "state not cleared after result")
    `IAE_ASSERT_IMP(a_err_value_zero, out_valid_reg && (out_status_reg != ST_OK), out_value_reg == '0, "nonzero value with error status")

endmodule

[design/infix_add_sub_evaluator_core.sv]
// ----------------------------------------------------------------------------
// infix_add_sub_evaluator_core
// Evaluates an infix '+', '-', '(' ')' expression fed one character per request.
// ----------------------------------------------------------------------------
//
//  channel   handshake         payload                        direction
//  --------  ----------------  -----------------------------  ---------
//  chars     push / full       char_code[7:0], end_of_expr.   in
//  result    pop / empty       value[31:0] signed, status[1:0] out
//
//  One character is taken per clock while the command queue between front
//  and back end has room; digits inside a number make no command.
//  The back end retires one command per clock in its execute state and
//  passes through a finish state per expression for the final reduction,
//  so a long run of very short expressions fills the queue and raises full.
//  When the back end is idle, empty falls after the last command passes the
//  queue and the execute and finish states; a waiting result holds the back
//  end, so the next expression enters only until the command queue fills.
//  Reset (rst_n low, async) empties the queues and zeroes all counts; the
//  stack memories need no clearing.
//
// Structure:
//  - iae_front builds decimal numbers (wrapping mod 2^32) and turns each
//    non-digit, or a digit that ends the expression, into a command.
//  - iae_cmd_fifo decouples the two sides.
//  - iae_back keeps the top two values in registers with the rest in a RAM,
//    and folds the operator stack into one pending operator per open
//    parenthesis level, so each command needs at most one add/subtract.
// ----------------------------------------------------------------------------
module infix_add_sub_evaluator_core #(
    parameter int unsigned VALUE_DEPTH    = 32,
    parameter int unsigned OPERATOR_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         char_code,
    input  logic               end_of_expression,
    input  logic               pop,
    output logic               empty,
    output logic signed [31:0] value,
    output logic [1:0]         status
);
    import iae_pkg::*;

    logic cmd_wr;
    logic cmd_full;
    logic cmd_rd;
    logic cmd_empty;
    cmd_t cmd_in;
    cmd_t cmd_out;

    // Character decode and number accumulation.
    iae_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .char_code         (char_code),
        .end_of_expression (end_of_expression),
        .cmd_wr            (cmd_wr),
        .cmd_data          (cmd_in),
        .cmd_full          (cmd_full)
    );

    // Decoupling queue.
    iae_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_rd),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // Stack engine and result register.
    iae_back #(
        .VALUE_DEPTH    (VALUE_DEPTH),
        .OPERATOR_DEPTH (OPERATOR_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_rd    (cmd_rd),
        .cmd_data  (cmd_out),
        .out_pop   (pop),
        .out_empty (empty),
        .value     (value),
        .status    (status)
    );

endmodule
